// ===== hw/rtl/char_lcd_nibble_sequencer_top_assert.svh =====
// Assertion macros for the character LCD nibble sequencer checkers.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication
`define CLNSEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CLNSEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/clnseq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clnseq_pkg;

    // Microprogram addressing
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_INIT = 4'd0;   // power-up routine, ten steps
    localparam step_t STEP_BYTE = 4'd10;  // generic byte send, two steps

    // Command codes
    typedef enum logic [2:0] {
        OP_INIT       = 3'd0,
        OP_PUTC       = 3'd1,
        OP_GOTO       = 3'd2,
        OP_CURSOR_ON  = 3'd3,
        OP_CURSOR_OFF = 3'd4
    } op_t;

    // Control word fields
    typedef enum logic [1:0] {
        NIB_CONST,
        NIB_HIGH,
        NIB_LOW
    } nib_sel_t;

    typedef enum logic {
        RS_INSTR,
        RS_CMD
    } rs_sel_t;

    typedef enum logic [1:0] {
        BEF_NONE,
        BEF_INIT,
        BEF_POWER
    } before_sel_t;

    typedef enum logic [1:0] {
        AFT_NONE,
        AFT_CMD,
        AFT_CLEAR,
        AFT_BYTE
    } after_sel_t;

    typedef struct packed {
        nib_sel_t    nib_sel;
        logic [3:0]  const_nib;
        rs_sel_t     rs_sel;
        before_sel_t before_sel;
        after_sel_t  after_sel;
        logic        done;
    } ctrl_word_t;

    // Decoded command, handed from the decoder to the sequencer
    typedef struct packed {
        logic       valid;
        step_t      entry;
        logic       rs;
        logic [7:0] data_byte;
        logic       long_wait;
    } cmd_info_t;

    // Waits in microseconds
    localparam logic [14:0] WAIT_POWER_US = 15'd22000;
    localparam logic [14:0] WAIT_INIT_US  = 15'd2000;
    localparam logic [10:0] WAIT_CMD_US   = 11'd40;
    localparam logic [10:0] WAIT_CLEAR_US = 11'd2040;

    // Character codes
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_FOLD  = 8'h07;

    // Display instructions
    localparam logic [7:0] INS_FUNC_SET    = 8'h28;
    localparam logic [7:0] INS_CLEAR       = 8'h01;
    localparam logic [7:0] INS_LINE2       = 8'hC0;
    localparam logic [7:0] INS_HOME        = 8'h80;
    localparam logic [7:0] INS_SHIFT_LEFT  = 8'h10;
    localparam logic [7:0] INS_DISP_CURSOR = 8'h0E;
    localparam logic [7:0] INS_DISP_ON     = 8'h0C;
    localparam logic [7:0] INS_SET_DDRAM   = 8'h80;
    localparam logic [7:0] ROW2_OFFSET     = 8'h40;
    localparam logic [1:0] ROW_SECOND      = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_sequencer_top.sv =====
// Character LCD nibble sequencer, 4-bit bus style.
// Slave channel s_*: one command word per handshake; s_tdata from bit 0 up
// holds operation[2:0], char_code[7:0], column[6:0], row[1:0].
// Master channel m_*: one nibble word per handshake; m_tdata holds nibble,
// wait_before_us and wait_after_us, m_tuser is register select, m_tlast marks
// the final nibble of a command.
// The command is registered into the step counter and operand registers, and
// each control word then loads the output register. Throughput: one nibble
// word per cycle while m_tready is high. Init runs the power-up routine and
// every other command the byte routine; unused operation codes are dropped.
// The step counter walks the microcode table one control word per cycle, and
// the next command is taken once the final word of a run is in the output
// register, so it may wait there while decoding starts.
// A stall on m_tready freezes the step counter and holds the output word.
// Reset clears the sequencer to idle with no output word pending.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // operation[2:0], char_code[10:3], column[17:11], row[19:18]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // nibble[3:0], wait_before_us[18:4], wait_after_us[29:19]
    output logic        m_tlast,
    output logic        m_tuser    // reg_select
);
    import clnseq_pkg::*;

    cmd_info_t  info;
    ctrl_word_t ctrl;

    logic       busy_reg;
    step_t      step_reg;
    logic       rs_reg;
    logic [7:0] byte_reg;
    logic       long_reg;

    logic        out_valid_reg;
    logic        out_rs_reg,  out_rs_next;
    logic [3:0]  out_nib_reg, out_nib_next;
    logic [14:0] out_bef_reg, out_bef_next;
    logic [10:0] out_aft_reg, out_aft_next;
    logic        out_last_reg;

    logic s_take;
    logic advance;

    clnseq_cmd_decode u_decode (
        .operation (s_tdata[2:0]),
        .char_code (s_tdata[10:3]),
        .column    (s_tdata[17:11]),
        .row       (s_tdata[19:18]),
        .info      (info)
    );

    clnseq_ucode_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    assign s_tready = !busy_reg;
    assign s_take   = s_tvalid && s_tready;
    assign advance  = busy_reg && (!out_valid_reg || m_tready);

    // Datapath driven by the control word
    always_comb
    begin
        unique case (ctrl.nib_sel)
            NIB_HIGH: out_nib_next = byte_reg[7:4];
            NIB_LOW:  out_nib_next = byte_reg[3:0];
            default:  out_nib_next = ctrl.const_nib;
        endcase

        unique case (ctrl.rs_sel)
            RS_CMD:   out_rs_next = rs_reg;
            default:  out_rs_next = 1'b0;
        endcase

        unique case (ctrl.before_sel)
            BEF_POWER: out_bef_next = WAIT_POWER_US;
            BEF_INIT:  out_bef_next = WAIT_INIT_US;
            default:   out_bef_next = 15'd0;
        endcase

        unique case (ctrl.after_sel)
            AFT_CMD:   out_aft_next = WAIT_CMD_US;
            AFT_CLEAR: out_aft_next = WAIT_CLEAR_US;
            AFT_BYTE:  out_aft_next = long_reg ? WAIT_CLEAR_US : WAIT_CMD_US;
            default:   out_aft_next = 11'd0;
        endcase
    end

    // Sequencer control: step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (ctrl.done)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + step_t'(1);
                end
            end
            else if (s_take && info.valid)
            begin
                busy_reg <= 1'b1;
                step_reg <= info.entry;
            end
        end
    end

    // Command operands
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            rs_reg   <= info.rs;
            byte_reg <= info.data_byte;
            long_reg <= info.long_wait;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rs_reg   <= out_rs_next;
            out_nib_reg  <= out_nib_next;
            out_bef_reg  <= out_bef_next;
            out_aft_reg  <= out_aft_next;
            out_last_reg <= ctrl.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_aft_reg, out_bef_reg, out_nib_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_rs_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/clnseq_ucode_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clnseq_ucode_rom (
    input  wire  clnseq_pkg::step_t      step,
    output clnseq_pkg::ctrl_word_t       ctrl
);
    import clnseq_pkg::*;

    // Microprogram: power-up routine, then the shared byte routine
    always_comb
    begin
        ctrl = '{nib_sel: NIB_CONST, const_nib: 4'h0, rs_sel: RS_INSTR,
                 before_sel: BEF_NONE, after_sel: AFT_NONE, done: 1'b1};
        unique case (step)
            4'd0:  ctrl = '{NIB_CONST, 4'h3, RS_INSTR, BEF_POWER, AFT_NONE,  1'b0};
            4'd1:  ctrl = '{NIB_CONST, 4'h3, RS_INSTR, BEF_INIT,  AFT_NONE,  1'b0};
            4'd2:  ctrl = '{NIB_CONST, 4'h3, RS_INSTR, BEF_INIT,  AFT_CMD,   1'b0};
            4'd3:  ctrl = '{NIB_CONST, 4'h2, RS_INSTR, BEF_NONE,  AFT_CMD,   1'b0};
            // function set 0x28
            4'd4:  ctrl = '{NIB_CONST, 4'h2, RS_INSTR, BEF_NONE,  AFT_NONE,  1'b0};
            4'd5:  ctrl = '{NIB_CONST, 4'h8, RS_INSTR, BEF_NONE,  AFT_CLEAR, 1'b0};
            // display on 0x0C
            4'd6:  ctrl = '{NIB_CONST, 4'h0, RS_INSTR, BEF_NONE,  AFT_NONE,  1'b0};
            4'd7:  ctrl = '{NIB_CONST, 4'hC, RS_INSTR, BEF_NONE,  AFT_CLEAR, 1'b0};
            // clear 0x01
            4'd8:  ctrl = '{NIB_CONST, 4'h0, RS_INSTR, BEF_NONE,  AFT_NONE,  1'b0};
            4'd9:  ctrl = '{NIB_CONST, 4'h1, RS_INSTR, BEF_NONE,  AFT_CLEAR, 1'b1};
            // byte routine
            4'd10: ctrl = '{NIB_HIGH,  4'h0, RS_CMD,   BEF_NONE,  AFT_NONE,  1'b0};
            4'd11: ctrl = '{NIB_LOW,   4'h0, RS_CMD,   BEF_NONE,  AFT_BYTE,  1'b1};
            default: ctrl = '{NIB_CONST, 4'h0, RS_INSTR, BEF_NONE, AFT_NONE, 1'b1};
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clnseq_cmd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clnseq_cmd_decode (
    input  wire  [2:0]             operation,
    input  wire  [7:0]             char_code,
    input  wire  [6:0]             column,
    input  wire  [1:0]             row,
    output clnseq_pkg::cmd_info_t  info
);
    import clnseq_pkg::*;

    logic [7:0] addr;

    // DDRAM address for goto, wrapping modulo 256 before the set bit
    always_comb
    begin
        addr = {1'b0, column} - 8'd1;
        if (row == ROW_SECOND)
        begin
            addr = addr + ROW2_OFFSET;
        end
    end

    // Pick the byte, register select and clear wait per command
    always_comb
    begin
        info = '{valid: 1'b1, entry: STEP_BYTE, rs: 1'b0, data_byte: 8'h00,
                 long_wait: 1'b0};
        unique case (operation)
            OP_INIT:
            begin
                info.entry = STEP_INIT;
            end
            OP_PUTC:
            begin
                priority if (char_code == CHR_FF)
                begin
                    info.data_byte = INS_CLEAR;
                    info.long_wait = 1'b1;
                end
                else if (char_code == CHR_NL)
                begin
                    info.data_byte = INS_LINE2;
                end
                else if (char_code == CHR_CR)
                begin
                    info.data_byte = INS_HOME;
                end
                else if (char_code == CHR_BS)
                begin
                    info.data_byte = INS_SHIFT_LEFT;
                end
                else if (char_code < CHR_SPACE)
                begin
                    info.rs        = 1'b1;
                    info.data_byte = char_code & CHR_FOLD;
                end
                else
                begin
                    info.rs        = 1'b1;
                    info.data_byte = char_code;
                end
            end
            OP_GOTO:
            begin
                info.data_byte = INS_SET_DDRAM | addr;
            end
            OP_CURSOR_ON:
            begin
                info.data_byte = INS_DISP_CURSOR;
            end
            OP_CURSOR_OFF:
            begin
                info.data_byte = INS_DISP_ON;
            end
            // unused codes give no nibbles
            default:
            begin
                info.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clnseq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_nibble_sequencer_top_assert.svh"

module clnseq_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tready,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,
    input  wire         m_tlast,
    input  wire         m_tuser
);

    // A stalled word holds still
    `CLNSEQ_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled nibble word changed")

    // No new command is taken while a run is still mid-way
    `CLNSEQ_ASSERT_IMP(a_run_busy, m_tvalid && !m_tlast, !s_tready, "command taken mid-run")

    // Every run ends on a nibble with a nonzero wait after it
    `CLNSEQ_ASSERT_IMP(a_last_wait, m_tvalid && m_tlast, m_tdata[29:19] != 11'd0, "last nibble has no wait")

    // Data nibbles never carry a pre-wait
    `CLNSEQ_ASSERT_IMP(a_data_nowait, m_tvalid && m_tuser, m_tdata[18:4] == 15'd0, "data nibble with pre-wait")

endmodule

bind char_lcd_nibble_sequencer_top clnseq_checker u_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import clnseq_pkg::*;

    // One nibble word as it leaves the sequencer
    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic [14:0] before_us;
        logic [10:0] after_us;
        logic        last;
    } nibble_word_t;

    // One pending command, tagged with the idling phase it is sent under
    typedef struct {
        logic [2:0] op;
        logic [7:0] ch;
        logic [6:0] col;
        logic [1:0] row;
        int         phase;
    } lcd_cmd_t;

    localparam int PH_NONE   = 0;
    localparam int PH_SENDER = 1;
    localparam int PH_RECV   = 2;
    localparam int PH_BOTH   = 3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // operation[2:0], char_code[10:3], column[17:11], row[19:18]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // nibble[3:0], wait_before_us[18:4], wait_after_us[29:19]
    logic        m_tlast;
    logic        m_tuser;         // reg_select

    lcd_cmd_t     cmd_queue[$];
    nibble_word_t expected_nibbles[$];
    int           cur_phase = PH_NONE;
    bit           s_took = 1'b0;
    int           errors = 0;

    char_lcd_nibble_sequencer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Expected nibble helpers
    function automatic void push_nibble(logic rs, logic [3:0] nib, logic [14:0] bef,
                                        logic [10:0] aft);
        nibble_word_t w;
        w.rs        = rs;
        w.nib       = nib;
        w.before_us = bef;
        w.after_us  = aft;
        w.last      = 1'b0;
        expected_nibbles.push_back(w);
    endfunction

    // High nibble first; only the low nibble carries the given wait after the byte
    function automatic void push_byte(logic rs, logic [7:0] b, logic [10:0] aft_low);
        push_nibble(rs, b[7:4], '0, '0);
        push_nibble(rs, b[3:0], '0, aft_low);
    endfunction

    // Works out the nibble run for one accepted command word
    function automatic void predict_nibbles(logic [23:0] word);
        logic [2:0] op;
        logic [7:0] ch;
        logic [6:0] col;
        logic [1:0] row;
        logic [7:0] adr;
        int         start;
        op    = word[2:0];
        ch    = word[10:3];
        col   = word[17:11];
        row   = word[19:18];
        start = expected_nibbles.size();
        case (op_t'(op))
            OP_INIT:
            begin
                push_nibble(RS_INSTR, 4'h3, WAIT_POWER_US, '0);
                push_nibble(RS_INSTR, 4'h3, WAIT_INIT_US, '0);
                push_nibble(RS_INSTR, 4'h3, WAIT_INIT_US, WAIT_CMD_US);
                push_nibble(RS_INSTR, 4'h2, '0, WAIT_CMD_US);
                push_byte(RS_INSTR, INS_FUNC_SET, WAIT_CLEAR_US);
                push_byte(RS_INSTR, INS_DISP_ON, WAIT_CLEAR_US);
                push_byte(RS_INSTR, INS_CLEAR, WAIT_CLEAR_US);
            end
            OP_PUTC:
            begin
                if (ch == CHR_FF)
                    push_byte(RS_INSTR, INS_CLEAR, WAIT_CLEAR_US);
                else if (ch == CHR_NL)
                    push_byte(RS_INSTR, INS_LINE2, WAIT_CMD_US);
                else if (ch == CHR_CR)
                    push_byte(RS_INSTR, INS_HOME, WAIT_CMD_US);
                else if (ch == CHR_BS)
                    push_byte(RS_INSTR, INS_SHIFT_LEFT, WAIT_CMD_US);
                else
                begin
                    // other control codes fold onto the custom glyphs
                    if (ch < CHR_SPACE)
                        ch = ch & CHR_FOLD;
                    push_byte(1'b1, ch, WAIT_CMD_US);
                end
            end
            OP_GOTO:
            begin
                adr = {1'b0, col} - 8'd1;
                if (row == ROW_SECOND)
                    adr = adr + ROW2_OFFSET;
                push_byte(RS_INSTR, INS_SET_DDRAM | adr, WAIT_CMD_US);
            end
            OP_CURSOR_ON:  push_byte(RS_INSTR, INS_DISP_CURSOR, WAIT_CMD_US);
            OP_CURSOR_OFF: push_byte(RS_INSTR, INS_DISP_ON, WAIT_CMD_US);
            default: ;
        endcase
        if (expected_nibbles.size() > start)
            expected_nibbles[expected_nibbles.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_cmd(logic [2:0] op, logic [7:0] ch, logic [6:0] col,
                                    logic [1:0] row, int phase);
        lcd_cmd_t c;
        c.op    = op;
        c.ch    = ch;
        c.col   = col;
        c.row   = row;
        c.phase = phase;
        cmd_queue.push_back(c);
    endfunction

    // Driver: new command words and ready change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_took)
            begin
                if (cmd_queue.size() > 0 &&
                    !((cur_phase == PH_SENDER && $urandom_range(0, 99) < 54) ||
                      (cur_phase == PH_BOTH && $urandom_range(0, 99) < 28)))
                begin
                    lcd_cmd_t c;
                    c = cmd_queue.pop_front();
                    cur_phase = c.phase;
                    s_tdata  <= {4'b0, c.row, c.col, c.ch, c.op};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !((cur_phase == PH_RECV && $urandom_range(0, 99) < 54) ||
                          (cur_phase == PH_BOTH && $urandom_range(0, 99) < 28));
        end
    end

    // Monitor: predict on accepted commands, check accepted nibble words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            s_took = s_tvalid && s_tready;
            if (s_took)
                predict_nibbles(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_nibbles.size() == 0)
                begin
                    $error("unexpected nibble word: tdata %08h tuser %0b tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end
                else
                begin
                    nibble_word_t e;
                    e = expected_nibbles.pop_front();
                    if (m_tuser !== e.rs)
                    begin
                        $error("reg_select: expected %0h, actual %0h", e.rs, m_tuser);
                        errors++;
                    end
                    if (m_tdata[3:0] !== e.nib)
                    begin
                        $error("nibble: expected %0h, actual %0h", e.nib, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tdata[18:4] !== e.before_us)
                    begin
                        $error("wait_before_us: expected %0d, actual %0d",
                               e.before_us, m_tdata[18:4]);
                        errors++;
                    end
                    if (m_tdata[29:19] !== e.after_us)
                    begin
                        $error("wait_after_us: expected %0d, actual %0d",
                               e.after_us, m_tdata[29:19]);
                        errors++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last: expected %0h, actual %0h", e.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int i;
        int r;
        logic [2:0] op;
        logic [7:0] ch;
        logic [6:0] col;
        logic [1:0] row;

        // directed: every operation, all special characters, field extremes
        add_cmd(OP_INIT, 8'hFF, 7'h7F, 2'd3, PH_NONE);
        add_cmd(OP_PUTC, 8'h00, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, 8'h07, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, CHR_BS, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, CHR_NL, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, CHR_FF, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, CHR_CR, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, 8'h10, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, 8'h1F, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, CHR_SPACE, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, 8'h7F, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_PUTC, 8'hFF, 7'h7F, 2'd3, PH_NONE);
        add_cmd(OP_GOTO, 8'h00, 7'd1, 2'd1, PH_NONE);
        add_cmd(OP_GOTO, 8'h00, 7'd64, 2'd2, PH_NONE);
        add_cmd(OP_GOTO, 8'h00, 7'd0, 2'd0, PH_NONE);
        add_cmd(OP_GOTO, 8'hFF, 7'd127, 2'd3, PH_NONE);
        add_cmd(OP_GOTO, 8'h00, 7'd1, 2'd2, PH_NONE);
        add_cmd(OP_CURSOR_ON, 8'hA5, 7'h2A, 2'd2, PH_NONE);
        add_cmd(OP_CURSOR_OFF, 8'h5A, 7'h55, 2'd1, PH_NONE);
        add_cmd(3'd5, 8'h00, 7'd1, 2'd1, PH_NONE);
        add_cmd(3'd6, 8'hFF, 7'd64, 2'd2, PH_NONE);
        add_cmd(3'd7, 8'h41, 7'd3, 2'd1, PH_NONE);
        add_cmd(OP_INIT, 8'h00, 7'd0, 2'd0, PH_NONE);

        // random: phases rotate every 25 commands
        for (i = 0; i < 187; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)      op = OP_INIT;
            else if (r < 55) op = OP_PUTC;
            else if (r < 75) op = OP_GOTO;
            else if (r < 85) op = OP_CURSOR_ON;
            else if (r < 95) op = OP_CURSOR_OFF;
            else             op = 3'($urandom_range(5, 7));
            ch  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(0, 255));
            col = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(1, 64))
                                               : 7'($urandom_range(0, 127));
            row = ($urandom_range(0, 99) < 80) ? 2'($urandom_range(1, 2))
                                               : 2'($urandom_range(0, 3));
            add_cmd(op, ch, col, row, (i / 25) % 4);
        end

        // single reset at the start
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_nibbles.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
